// File: rtl/msfft_pkg.sv
// Package: shared types, event codes and constants of the frame timer
package msfft_pkg;

	localparam int NUM_TIMERS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int LEFT_W            = 17;
	localparam int PERIOD_W          = 16;
	localparam int ID_W              = 32;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_ADD    = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_ADDED     = 3'd0,
		EV_FULL      = 3'd1,
		EV_CANCELLED = 3'd2,
		EV_NOT_FOUND = 3'd3,
		EV_FIRED     = 3'd4,
		EV_DONE      = 3'd5
	} ev_t;

	typedef struct packed {
		op_t                 op;
		logic [PERIOD_W-1:0] frames;
		logic [15:0]         fraction;
		logic                rep;
		logic [ID_W-1:0]     target;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} st_t;

endpackage

// File: rtl/multi_slot_fractional_frame_timer_top.sv
// Top level: multi-slot fractional frame timer
// Add and cancel are answered straight from the idle state of the back end; a tick walks the live
// slots one per cycle while the output is not stalled, then gives a done event. A
// two-entry command queue lets the front accept items while the back end walks.
module multi_slot_fractional_frame_timer_top
	import msfft_pkg::*;
#(
	parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      operation,
	input  logic [15:0]     period_frames,
	input  logic [15:0]     period_fraction,
	input  logic            repeat_mode,
	input  logic [ID_W-1:0] target_id,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      event_kind,
	output logic [ID_W-1:0] timer_id,
	output logic            last
);

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;

	assign in_cmd = '{op: op_t'(operation), frames: period_frames,
		fraction: period_fraction, rep: repeat_mode, target: target_id};

	msfft_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	msfft_back #(.NUM_TIMERS(NUM_TIMERS), .FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.out_valid, .out_ready, .event_kind, .timer_id, .last
	);

endmodule

// File: rtl/msfft_front.sv
// Front end: accepts items, drops unknown operations, queues commands
module msfft_front
	import msfft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cmd_t        in_cmd,
	output logic        q_valid,
	input  logic        q_ready,
	output cmd_t        q_cmd
);

	cmd_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && (in_cmd.op != OP_NONE);
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_cmd;
	end

endmodule

// File: rtl/msfft_back.sv
// Back end: timer slot list, add, cancel and tick walk with result register
module msfft_back
	import msfft_pkg::*;
#(
	parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  cmd_t            q_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      event_kind,
	output logic [ID_W-1:0] timer_id,
	output logic            last
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int AW = FRACTION_BITS + 1;
	localparam logic [AW:0] FIX_ONE = (AW+1)'(1) << FRACTION_BITS;

	logic [ID_W-1:0]          id_q   [NUM_TIMERS];
	logic [LEFT_W-1:0]        left_q [NUM_TIMERS];
	logic [PERIOD_W-1:0]      per_q  [NUM_TIMERS];
	logic [FRACTION_BITS-1:0] frac_q [NUM_TIMERS];
	logic [AW-1:0]            acc_q  [NUM_TIMERS];
	logic                     rec_q  [NUM_TIMERS];

	logic [CW-1:0]   count_q;
	logic [ID_W-1:0] next_id_q;
	st_t             st_q, st_d;
	logic [CW-1:0]   idx_q;
	logic            ov_q;
	logic [2:0]      ok_q;
	logic [ID_W-1:0] oid_q;
	logic            ol_q;

	logic                     out_free;
	logic                     ov_set;
	logic                     walk_end;
	logic [IW-1:0]            cur;
	logic [LEFT_W-1:0]        dec;
	logic [AW:0]              acc_sum;
	logic [AW:0]              acc_new;
	logic                     acc_carry;
	logic [FRACTION_BITS-1:0] frac_in;
	logic [PERIOD_W-1:0]      frames_in;
	logic                     hit;
	logic [IW-1:0]            hit_idx;
	logic                     rm;
	logic [IW-1:0]            rm_idx;

	assign out_free   = !ov_q || out_ready;
	assign out_valid  = ov_q;
	assign event_kind = ok_q;
	assign timer_id   = oid_q;
	assign last       = ol_q;

	assign walk_end  = (idx_q >= count_q);
	assign cur       = idx_q[IW-1:0];
	assign dec       = left_q[cur] - LEFT_W'(1);
	assign acc_sum   = {1'b0, acc_q[cur]} + (AW+1)'(frac_q[cur]);
	assign acc_carry = acc_sum > FIX_ONE;
	assign acc_new   = acc_carry ? acc_sum - FIX_ONE : acc_sum;
	assign frames_in = (q_cmd.frames == '0) ? PERIOD_W'(1) : q_cmd.frames;

	generate
		if (FRACTION_BITS >= 16) begin : g_wide
			assign frac_in = FRACTION_BITS'({q_cmd.fraction, {(FRACTION_BITS-16+1){1'b0}}} >> 1);
		end else begin : g_narrow
			assign frac_in = q_cmd.fraction[15 -: FRACTION_BITS];
		end
	endgenerate

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
			if (CW'(k) < count_q && id_q[k] == q_cmd.target) begin
				hit     = 1'b1;
				hit_idx = IW'(k);
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (q_valid && out_free && q_cmd.op == OP_TICK) st_d = ST_WALK;
			ST_WALK: if (walk_end) st_d = ST_DONE;
			ST_DONE: if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = 1'b0;
		rm      = 1'b0;
		rm_idx  = cur;
		ov_set  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				q_ready = out_free && (q_cmd.op != OP_TICK);
				ov_set  = q_valid && out_free &&
					(q_cmd.op == OP_ADD || q_cmd.op == OP_CANCEL);
				if (q_valid && out_free && q_cmd.op == OP_CANCEL && hit) begin
					rm     = 1'b1;
					rm_idx = hit_idx;
				end
			end
			ST_WALK: begin
				rm     = !walk_end && out_free && dec == '0 && !rec_q[cur];
				ov_set = !walk_end && out_free && dec == '0;
			end
			ST_DONE: begin
				q_ready = out_free;
				ov_set  = out_free;
			end
			default: q_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			count_q   <= '0;
			next_id_q <= '0;
			idx_q     <= '0;
			ov_q      <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ov_set) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (rm) count_q <= count_q - CW'(1);
			unique case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (q_valid && out_free && q_cmd.op == OP_ADD) begin
						if (count_q < CW'(NUM_TIMERS)) begin
							count_q   <= count_q + CW'(1);
							next_id_q <= next_id_q + ID_W'(1);
						end
					end
				end
				ST_WALK: begin
					if (!walk_end && out_free) begin
						if (!(dec == '0 && !rec_q[cur])) idx_q <= idx_q + CW'(1);
					end
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rm) begin
			for (int k = 0; k < NUM_TIMERS - 1; k++) begin
				if (IW'(k) >= rm_idx) begin
					id_q[k]   <= id_q[k+1];
					left_q[k] <= left_q[k+1];
					per_q[k]  <= per_q[k+1];
					frac_q[k] <= frac_q[k+1];
					acc_q[k]  <= acc_q[k+1];
					rec_q[k]  <= rec_q[k+1];
				end
			end
		end
		unique case (st_q)
			ST_IDLE: begin
				if (q_valid && out_free && q_cmd.op == OP_ADD) begin
					ol_q <= 1'b1;
					if (count_q < CW'(NUM_TIMERS)) begin
						id_q[count_q[IW-1:0]]   <= next_id_q;
						left_q[count_q[IW-1:0]] <= LEFT_W'(frames_in);
						per_q[count_q[IW-1:0]]  <= frames_in;
						frac_q[count_q[IW-1:0]] <= frac_in;
						acc_q[count_q[IW-1:0]]  <= '0;
						rec_q[count_q[IW-1:0]]  <= q_cmd.rep;
						ok_q  <= EV_ADDED;
						oid_q <= next_id_q;
					end else begin
						ok_q  <= EV_FULL;
						oid_q <= '0;
					end
				end else if (q_valid && out_free && q_cmd.op == OP_CANCEL) begin
					ol_q  <= 1'b1;
					ok_q  <= hit ? EV_CANCELLED : EV_NOT_FOUND;
					oid_q <= hit ? q_cmd.target : '0;
				end
			end
			ST_WALK: begin
				if (!walk_end && out_free) begin
					if (dec == '0) begin
						ok_q  <= EV_FIRED;
						oid_q <= id_q[cur];
						ol_q  <= 1'b0;
						if (rec_q[cur]) begin
							acc_q[cur]  <= acc_new[AW-1:0];
							left_q[cur] <= LEFT_W'(per_q[cur]) + LEFT_W'(acc_carry);
						end
					end else begin
						left_q[cur] <= dec;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ok_q  <= EV_DONE;
					oid_q <= '0;
					ol_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/msfft_checker.sv
// Checker: port-level properties of the frame timer, bound to the top level
module msfft_checker
	import msfft_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_kind,
	input logic [31:0] timer_id,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(timer_id))
		else $error("result changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_FIRED) |-> !last)
		else $error("fire event marked last");

	a_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != EV_FIRED) |-> last)
		else $error("final result not marked last");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_FULL || event_kind == EV_NOT_FOUND ||
		event_kind == EV_DONE) |-> timer_id == '0)
		else $error("non-zero id on idless result");

endmodule

bind multi_slot_fractional_frame_timer_top msfft_checker u_checker (
	.clk, .arst_n, .out_valid, .out_ready, .event_kind, .timer_id, .last
);

// File: sim/frame_timer_checker.sv
// Checker: watches both channels of the frame timer, predicts its events and compares them
`timescale 1ns / 100ps
module frame_timer_checker
	import msfft_pkg::*;
#(
	parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic [1:0]      operation,
	input  logic [15:0]     period_frames,
	input  logic [15:0]     period_fraction,
	input  logic            repeat_mode,
	input  logic [ID_W-1:0] target_id,
	input  logic            out_valid,
	input  logic            out_ready,
	input  logic [2:0]      event_kind,
	input  logic [ID_W-1:0] timer_id,
	input  logic            last,
	output int              fail_count,
	output int              pending_events
);

	typedef struct packed {
		ev_t             kind;
		logic [ID_W-1:0] id;
		logic            fin;
	} timer_event_t;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic [LEFT_W-1:0]        left;
		logic [PERIOD_W-1:0]      period;
		logic [FRACTION_BITS-1:0] fraction;
		logic [FRACTION_BITS:0]   acc;
		logic                     recurring;
	} timer_slot_t;

	timer_event_t expected_events[$];
	timer_slot_t  slots[NUM_TIMERS];
	int           live;
	logic [ID_W-1:0] id_counter;

	assign pending_events = expected_events.size();

	function automatic logic [FRACTION_BITS-1:0] scaled_fraction(logic [15:0] f);
		if (FRACTION_BITS >= 16)
			return FRACTION_BITS'(f) << (FRACTION_BITS - 16);
		return FRACTION_BITS'(f >> (16 - FRACTION_BITS));
	endfunction

	task automatic drop_slot(int idx);
		for (int j = idx; j + 1 < live; j++)
			slots[j] = slots[j + 1];
		live--;
	endtask

	task automatic predict_timer_events(op_t op, logic [15:0] fr, logic [15:0] fx,
			logic rp, logic [ID_W-1:0] tgt);
		int i;
		logic [FRACTION_BITS+1:0] sum;
		logic [LEFT_W-1:0] extra;
		bit hit;
		case (op)
			OP_ADD: begin
				if (live >= NUM_TIMERS) begin
					expected_events.push_back('{EV_FULL, '0, 1'b1});
				end else begin
					slots[live] = '{id_counter, LEFT_W'((fr == 0) ? 16'd1 : fr),
						(fr == 0) ? 16'd1 : fr, scaled_fraction(fx), '0, rp};
					live++;
					expected_events.push_back('{EV_ADDED, id_counter, 1'b1});
					id_counter++;
				end
			end
			OP_CANCEL: begin
				hit = 0;
				for (i = 0; i < live && !hit; i++)
					if (slots[i].id == tgt) begin
						drop_slot(i);
						hit = 1;
					end
				if (hit)
					expected_events.push_back('{EV_CANCELLED, tgt, 1'b1});
				else
					expected_events.push_back('{EV_NOT_FOUND, '0, 1'b1});
			end
			OP_TICK: begin
				i = 0;
				while (i < live) begin
					slots[i].left = slots[i].left - 1'b1;
					if (slots[i].left != 0) begin
						i++;
					end else begin
						expected_events.push_back('{EV_FIRED, slots[i].id, 1'b0});
						if (slots[i].recurring) begin
							sum = slots[i].acc + slots[i].fraction;
							extra = 0;
							while (sum > (1 << FRACTION_BITS)) begin
								sum -= (1 << FRACTION_BITS);
								extra++;
							end
							slots[i].acc = sum[FRACTION_BITS:0];
							slots[i].left = extra + slots[i].period;
							i++;
						end else begin
							drop_slot(i);
						end
					end
				end
				expected_events.push_back('{EV_DONE, '0, 1'b1});
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_event_t exp_ev;
		if (!arst_n) begin
			fail_count = 0;
			live = 0;
			id_counter = '0;
			expected_events.delete();
		end else begin
			if (in_valid && in_ready)
				predict_timer_events(op_t'(operation), period_frames, period_fraction,
					repeat_mode, target_id);
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected event kind %0d id %0d last %0d", $time,
						event_kind, timer_id, last);
				end else begin
					exp_ev = expected_events.pop_front();
					if (event_kind !== exp_ev.kind || timer_id !== exp_ev.id
							|| last !== exp_ev.fin) begin
						fail_count++;
						$display("%0t: expected kind %0d id %0d last %0d, got %0d %0d %0d",
							$time, exp_ev.kind, exp_ev.id, exp_ev.fin,
							event_kind, timer_id, last);
					end
				end
			end
		end
	end

endmodule

// File: sim/tb_multi_slot_fractional_frame_timer_top.sv
// Testbench top: drives commands into the frame timer and gives the verdict
`timescale 1ns / 100ps
module tb_multi_slot_fractional_frame_timer_top
	import msfft_pkg::*;
;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [1:0]      operation;
	logic [15:0]     period_frames;
	logic [15:0]     period_fraction;
	logic            repeat_mode;
	logic [ID_W-1:0] target_id;
	logic            out_valid;
	logic            out_ready;
	logic [2:0]      event_kind;
	logic [ID_W-1:0] timer_id;
	logic            last;
	int              fail_count;
	int              pending_events;
	int              cycle_count;
	bit              calm;
	bit              hold_off;
	logic [ID_W-1:0] ids_issued;

	multi_slot_fractional_frame_timer_top dut (.*);

	frame_timer_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("tb_multi_slot_fractional_frame_timer_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_off && (calm || $urandom_range(99) >= 14);
	end

	task automatic send_cmd(op_t op, logic [15:0] fr, logic [15:0] fx, logic rp,
			logic [ID_W-1:0] tgt);
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= op;
		period_frames   <= fr;
		period_fraction <= fx;
		repeat_mode     <= rp;
		target_id       <= tgt;
		do
			@(posedge clk);
		while (!in_ready);
		if (op == OP_ADD)
			ids_issued++;
	endtask

	task automatic send_random_cmd();
		int pick;
		logic [ID_W-1:0] tgt;
		pick = $urandom_range(99);
		tgt = (ids_issued != 0 && $urandom_range(3) != 0) ?
			ids_issued - 1 - $urandom_range(8) : $urandom;
		if (pick < 45)
			send_cmd(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom), $urandom);
		else if (pick < 75)
			send_cmd(OP_ADD, 16'($urandom_range(4)), 16'($urandom), 1'($urandom),
				$urandom);
		else if (pick < 80)
			send_cmd(OP_ADD, 16'($urandom), 16'($urandom), 1'($urandom), $urandom);
		else if (pick < 96)
			send_cmd(OP_CANCEL, 16'($urandom), 16'($urandom), 1'($urandom), tgt);
		else
			send_cmd(OP_NONE, 16'($urandom), 16'($urandom), 1'($urandom), $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		period_frames = '0;
		period_fraction = '0;
		repeat_mode = 1'b0;
		target_id = '0;
		cycle_count = 0;
		calm = 1'b0;
		hold_off = 1'b0;
		ids_issued = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_TICK, 16'h0, 16'h0, 1'b0, '0);
		send_cmd(OP_CANCEL, 16'h0, 16'h0, 1'b0, 32'hFFFF_FFFF);
		send_cmd(OP_ADD, 16'h0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		send_cmd(OP_ADD, 16'h1, 16'h8000, 1'b1, '0);
		send_cmd(OP_ADD, 16'h2, 16'h0000, 1'b0, '0);
		send_cmd(OP_ADD, 16'hFFFF, 16'h0001, 1'b0, '0);
		send_cmd(OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		repeat (4)
			send_cmd(OP_TICK, 16'h0, 16'h0, 1'b0, '0);
		send_cmd(OP_CANCEL, 16'h0, 16'h0, 1'b0, 32'd3);
		send_cmd(OP_CANCEL, 16'h0, 16'h0, 1'b0, 32'd3);
		for (int k = 0; k < 15; k++)
			send_cmd(OP_ADD, 16'(k % 3), 16'(k * 16'h1111), 1'(k), '0);
		send_cmd(OP_TICK, 16'h0, 16'h0, 1'b0, '0);
		in_valid <= 1'b0;

		@(posedge clk);
		wait (pending_events == 0);
		calm = 1'b1;
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				repeat (20) send_random_cmd();
				in_valid <= 1'b0;
			end
		join
		@(posedge clk);
		wait (pending_events == 0);
		calm = 1'b0;
		repeat (50) send_random_cmd();
		in_valid <= 1'b0;

		@(posedge clk);
		wait (pending_events == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb_multi_slot_fractional_frame_timer_top OK");
		else
			$display("tb_multi_slot_fractional_frame_timer_top NOT OK");
		$finish;
	end

endmodule
